// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file skht_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/skht_pkg.sv -----
// ----------------------------------------------------------------------------
// skht_pkg
// Shared constants and the controller/datapath command and status types of the
// string key hash table.
// ----------------------------------------------------------------------------
package skht_pkg;

    // slot count is tied to the 10-bit slot and 11-bit count ports; a power of
    // two, so the home slot is the low hash bits
    localparam int TABLE_SLOTS = 1024;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic       absorb;      // take one key byte
        logic       home_load;   // start the probe at the home slot
        logic       advance;     // step to the next slot with wrap
        logic       clr_wr;      // clear one metadata entry
        logic       meta_wr;     // mark slot used with pending length
        logic       cnt_inc;
        logic       j_clr;
        logic       j_inc;
        logic       copy_wr;     // store one pending byte into the slot
        logic       out_load;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic meta_valid;
        logic len_eq;
        logic len_zero;
        logic byte_eq;
        logic j_last;
        logic probe_last;
        logic idx_last;
        logic out_free;
    } t_sts;

    // hash = (hash ^ byte) * 1099511628211, prime = 2^40 + 0x1B3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ----- design/skht_ram.sv -----
// ----------------------------------------------------------------------------
// skht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/skht_ctrl.sv -----
// ----------------------------------------------------------------------------
// skht_ctrl
// Sequencer of the hash table: clearing pass, byte intake, home slot load,
// linear probe with byte compare, key copy on insert, result.
// ----------------------------------------------------------------------------
module skht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_action,
    input  logic          i_key_last,
    output logic          o_stall,
    input  skht_pkg::t_sts i_sts,
    output skht_pkg::t_cmd o_cmd
);
    import skht_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HOME   = 4'd3;
    localparam logic [3:0] S_META   = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_NEXT   = 4'd6;
    localparam logic [3:0] S_CMPRD  = 4'd7;
    localparam logic [3:0] S_CMPCK  = 4'd8;
    localparam logic [3:0] S_COPYRD = 4'd9;
    localparam logic [3:0] S_COPYWR = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_action, n_action;
    logic [1:0] r_stat, n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_action <= 1'b0;
            r_stat   <= ST_NOTFOUND;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
            r_stat   <= n_stat;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_stat   = r_stat;
        o_cmd    = '0;
        o_cmd.out_status = r_stat;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.absorb = 1'b1;
                    if (i_key_last) begin
                        n_action = i_action;
                        n_state  = S_HOME;
                    end
                end
            end
            S_HOME: begin
                o_cmd.home_load = 1'b1;
                n_state = S_META;
            end
            S_META: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.meta_valid) begin
                    if (r_action) begin
                        o_cmd.meta_wr = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.j_clr   = 1'b1;
                        n_stat  = ST_INSERTED;
                        n_state = i_sts.len_zero ? S_FIN : S_COPYRD;
                    end else begin
                        n_stat  = ST_NOTFOUND;
                        n_state = S_FIN;
                    end
                end else if (i_sts.len_eq) begin
                    o_cmd.j_clr = 1'b1;
                    if (i_sts.len_zero) begin
                        n_stat  = ST_FOUND;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CMPRD;
                    end
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.probe_last) begin
                    n_stat  = r_action ? ST_FULL : ST_NOTFOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_META;
                end
            end
            S_CMPRD: begin
                n_state = S_CMPCK;
            end
            S_CMPCK: begin
                if (!i_sts.byte_eq) begin
                    n_state = S_NEXT;
                end else if (i_sts.j_last) begin
                    n_stat  = ST_FOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_CMPRD;
                end
            end
            S_COPYRD: begin
                n_state = S_COPYWR;
            end
            S_COPYWR: begin
                o_cmd.copy_wr = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_COPYRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- design/skht_dp.sv -----
// ----------------------------------------------------------------------------
// skht_dp
// Datapath of the hash table: running hash, pending key, home slot,
// probe pointers, slot metadata and key byte memories, result register.
// ----------------------------------------------------------------------------
module skht_dp #(
    parameter int KEY_BUFFER_BYTES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_key_byte,
    input  logic           i_stall,
    input  skht_pkg::t_cmd i_cmd,
    output skht_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [9:0]     o_slot,
    output logic [10:0]    o_entry_count
);
    import skht_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int LW = $clog2(KEY_BUFFER_BYTES);
    localparam int KW = $clog2(TABLE_SLOTS * KEY_BUFFER_BYTES);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [63:0]   r_hash;
    logic [LW-1:0] r_plen;
    logic [LW-1:0] r_j;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_probe;
    logic [KW-1:0] r_base;
    logic [CW-1:0] r_count;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [9:0]    r_slot;
    logic [CW-1:0] r_ocount;

    logic          keep;
    logic [SW-1:0] home;
    logic          idx_wrap;
    logic [LW:0]   meta_wdata;
    logic [LW:0]   meta_rdata;
    logic [7:0]    key_rdata;
    logic [7:0]    pend_rdata;
    logic [KW-1:0] key_addr;

    assign keep = i_cmd.absorb && (i_key_byte != 8'd0)
                  && (r_plen < LW'(KEY_BUFFER_BYTES - 1));

    // slot count is a power of two: the home slot is the low hash bits
    assign home = r_hash[SW-1:0];

    assign idx_wrap = (r_idx == SW'(TABLE_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= FNV_BASIS;
            r_plen   <= '0;
            r_idx    <= '0;
            r_probe  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (keep) begin
                r_hash <= fnv_step(r_hash, i_key_byte);
                r_plen <= r_plen + LW'(1);
            end else if (i_cmd.out_load) begin
                r_hash <= FNV_BASIS;
                r_plen <= '0;
            end
            if (i_cmd.home_load) begin
                r_idx   <= home;
                r_probe <= '0;
            end else if (i_cmd.advance || i_cmd.clr_wr) begin
                r_idx <= idx_wrap ? '0 : r_idx + SW'(1);
                if (i_cmd.advance) begin
                    r_probe <= r_probe + SW'(1);
                end
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.home_load) begin
            r_base <= KW'(home) * KW'(KEY_BUFFER_BYTES);
        end else if (i_cmd.advance) begin
            r_base <= idx_wrap ? '0 : r_base + KW'(KEY_BUFFER_BYTES);
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + LW'(1);
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_slot   <= (i_cmd.out_status == ST_FOUND || i_cmd.out_status == ST_INSERTED)
                        ? 10'(r_idx) : 10'd0;
            r_ocount <= r_count;
        end
    end

    assign meta_wdata = i_cmd.clr_wr ? '0 : {1'b1, r_plen};
    assign key_addr   = r_base + KW'(r_j);

    skht_ram #(.WIDTH(LW + 1), .DEPTH(TABLE_SLOTS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr || i_cmd.meta_wr),
        .i_waddr (r_idx),
        .i_wdata (meta_wdata),
        .i_raddr (r_idx),
        .o_rdata (meta_rdata)
    );

    skht_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * KEY_BUFFER_BYTES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.copy_wr),
        .i_waddr (key_addr),
        .i_wdata (pend_rdata),
        .i_raddr (key_addr),
        .o_rdata (key_rdata)
    );

    skht_ram #(.WIDTH(8), .DEPTH(KEY_BUFFER_BYTES)) u_pend (
        .i_clk   (i_clk),
        .i_we    (keep),
        .i_waddr (r_plen),
        .i_wdata (i_key_byte),
        .i_raddr (r_j),
        .o_rdata (pend_rdata)
    );

    always_comb begin
        o_sts.meta_valid = meta_rdata[LW];
        o_sts.len_eq     = (meta_rdata[LW-1:0] == r_plen);
        o_sts.len_zero   = (r_plen == '0);
        o_sts.byte_eq    = (key_rdata == pend_rdata);
        o_sts.j_last     = (r_j == r_plen - LW'(1));
        o_sts.probe_last = (r_probe == SW'(TABLE_SLOTS - 1));
        o_sts.idx_last   = idx_wrap;
        o_sts.out_free   = !r_ovalid || !i_stall;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_count = 11'(r_ocount);
endmodule

// ----- design/string_key_hash_table.sv -----
// ----------------------------------------------------------------------------
// string_key_hash_table
// Open-addressing table keyed by byte strings, FNV-1a 64 hash, linear probe.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one key byte per beat with i_key_last on
// the final byte; i_action (find or find-or-insert) is sampled with it. Zero
// bytes and bytes beyond KEY_BUFFER_BYTES-1 are dropped, i_key_last counts.
// A non-last byte gives no result. A last byte loads the home slot, reads the
// metadata of each slot passed over and of the slot that ends the search,
// compares key bytes one by one at a slot whose stored length matches, copies
// the key bytes into the slot on insert, and loads the result register. Each
// slot and each compared or copied byte waits on a registered memory read.
// Output channel (o_valid / i_stall): o_status, o_slot, o_entry_count per
// beat, held in a result register; while the receiver stalls, the block can
// still take key bytes and probe, and waits only to load the next result.
// After reset, a clearing pass over all TABLE_SLOTS entries empties the slot
// metadata; o_stall stays high until it finishes.
// ----------------------------------------------------------------------------
module string_key_hash_table #(
    parameter int KEY_BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [10:0] o_entry_count
);
    import skht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    skht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_key_last (i_key_last),
        .o_stall    (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skht_dp #(
        .KEY_BUFFER_BYTES (KEY_BUFFER_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_byte    (i_key_byte),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_entry_count (o_entry_count)
    );
endmodule

// ----- design/skht_chk.sv -----
// ----------------------------------------------------------------------------
// skht_chk
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skht_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_key_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [9:0]  o_slot
);
    import skht_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_slot_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_slot))
    `ASSERT_IMPLY(a_miss_slot, i_clk, i_rst_n, o_valid && (o_status == ST_NOTFOUND || o_status == ST_FULL), o_slot == 10'd0)
    `ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_valid && !o_stall && i_key_last, o_stall)
endmodule

bind string_key_hash_table skht_chk u_skht_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_key_last (i_key_last),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_slot     (o_slot)
);

// ----- test/tb_string_key_hash_table.sv -----
// ----------------------------------------------------------------------------
// tb_string_key_hash_table
// Drives key bytes into the hash table and checks each lookup reply against a
// behavioral table kept in the testbench: FNV-1a 64 hashing, linear probing,
// long and empty keys, dropped zero bytes and back pressure.
// ----------------------------------------------------------------------------
module tb_string_key_hash_table;
    timeunit 1ns;
    timeprecision 1ps;
    import skht_pkg::*;

    localparam int SLOTS     = 1024;
    localparam int KEY_BYTES = 64;
    localparam int MAX_KEEP  = KEY_BYTES - 1;
    localparam longint unsigned PRIME = 64'd1099511628211;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [10:0] count;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_action = 1'b0;
    logic [7:0]  i_key_byte = 8'd0;
    logic        i_key_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [9:0]  o_slot;
    logic [10:0] o_entry_count;

    // testbench copy of the table
    bit              tbl_used [SLOTS];
    int unsigned     tbl_len [SLOTS];
    logic [7:0]      tbl_key [SLOTS][KEY_BYTES];
    logic [7:0]      key_buf [KEY_BYTES];
    int unsigned     key_len;
    longint unsigned key_hash;
    int unsigned     used_count;

    t_reply expected_replies[$];
    int     errors;
    int     cycles;
    int     stall_pct;      // receiver stall percentage
    int     gap_max;        // longest sender gap
    int     burst_left;
    int     hold_left;      // long receiver hold-off
    logic [7:0] pool [40][$];

    string_key_hash_table i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL string_key_hash_table");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_replies.size() == 0) begin
                report("unexpected reply status", o_status, -1);
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_slot !== want.slot) report("slot", o_slot, want.slot);
                if (o_entry_count !== want.count) report("entry_count", o_entry_count, want.count);
            end
        end
    end

    function automatic bit key_matches(int unsigned s);
        if (tbl_len[s] != key_len) return 0;
        for (int unsigned j = 0; j < key_len; j++)
            if (tbl_key[s][j] != key_buf[j]) return 0;
        return 1;
    endfunction

    // fold one accepted beat into the table copy, queue a reply on the last byte
    task automatic table_lookup(input logic act, input logic [7:0] b, input logic last);
        t_reply r;
        int unsigned home, idx;
        if (b != 0 && key_len < MAX_KEEP) begin
            key_buf[key_len] = b;
            key_len++;
            key_hash = (key_hash ^ longint'(b)) * PRIME;
        end
        if (last) begin
            home     = int'(key_hash % SLOTS);
            r.status = act ? ST_FULL : ST_NOTFOUND;
            r.slot   = '0;
            for (int i = 0; i < SLOTS; i++) begin
                idx = (home + i) % SLOTS;
                if (!tbl_used[idx]) begin
                    if (act) begin
                        tbl_used[idx] = 1;
                        tbl_len[idx]  = key_len;
                        for (int j = 0; j < key_len; j++) tbl_key[idx][j] = key_buf[j];
                        used_count++;
                        r.status = ST_INSERTED;
                        r.slot   = 10'(idx);
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                    break;
                end
                if (key_matches(idx)) begin
                    r.status = ST_FOUND;
                    r.slot   = 10'(idx);
                    break;
                end
            end
            r.count = 11'(used_count);
            expected_replies.push_back(r);
            key_len  = 0;
            key_hash = FNV_BASIS;
        end
    endtask

    task automatic send_beat(input logic act, input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_action   <= act;
        i_key_byte <= b;
        i_key_last <= last;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        table_lookup(act, b, last);
    endtask

    // send a whole key; non-last beats carry a random action
    task automatic send_key(input logic act, input logic [7:0] k[$]);
        if (k.size() == 0) begin
            send_beat(act, 8'd0, 1'b1);
        end else begin
            for (int i = 0; i < k.size(); i++)
                send_beat((i == k.size() - 1) ? act : 1'($urandom), k[i], i == k.size() - 1);
        end
    endtask

    // drop valid so the last beat is not taken twice, then wait for every queued reply
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [7:0] k[$];
        send_key(1'b0, k);                       // empty key, absent
        send_key(1'b1, k);
        send_key(1'b0, k);
        k = '{8'd1};
        send_key(1'b1, k);
        k = '{8'd255};
        send_key(1'b0, k);
        send_key(1'b1, k);
        send_key(1'b1, k);                       // already present
        k = '{8'd1, 8'd0, 8'd255, 8'd0};         // zero bytes dropped
        send_key(1'b1, k);
        k = '{8'd1, 8'd255};
        send_key(1'b0, k);
        k = {};
        for (int i = 0; i < 70; i++) k.push_back(8'($urandom_range(1, 255)));
        send_key(1'b1, k);
        for (int i = MAX_KEEP; i < 70; i++) k[i] = 8'($urandom_range(1, 255));
        send_key(1'b0, k);                       // tail past the buffer ignored
        k = k[0:MAX_KEEP - 2];
        send_key(1'b0, k);
        wait_drained();
    endtask

    task automatic test_random(input int beats);
        int sent;
        logic [7:0] k[$];
        int p;
        sent = 0;
        while (sent < beats) begin
            p = $urandom_range(0, 39);
            if ($urandom_range(0, 9) < 6) begin
                k = pool[p];
            end else begin
                k = {};
                repeat ($urandom_range(0, 9)) k.push_back(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 19) == 0)
                    repeat ($urandom_range(50, 80)) k.push_back(8'($urandom));
                if ($urandom_range(0, 7) == 0) k.insert($urandom_range(0, k.size()), 8'd0);
                if ($urandom_range(0, 3) == 0) pool[p] = k;
            end
            send_key(1'($urandom), k);
            sent += (k.size() == 0) ? 1 : k.size();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        logic [7:0] k[$];
        hold_left = 3000;
        for (int i = 0; i < 40; i++) begin
            k = '{8'($urandom_range(1, 255))};
            send_key(1'($urandom), k);
        end
        wait_drained();
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        hold_left  = 0;
        stall_pct  = 0;
        gap_max    = 0;
        key_len    = 0;
        key_hash   = FNV_BASIS;
        used_count = 0;
        foreach (tbl_used[s]) tbl_used[s] = 0;
        foreach (pool[p]) pool[p].push_back(8'($urandom_range(1, 255)));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        stall_pct = 30;
        gap_max   = 6;
        test_random(250);
        stall_pct = 0;
        gap_max   = 0;
        test_random(100);
        stall_pct = 50;
        gap_max   = 3;
        test_random(200);
        test_backpressure();

        i_valid <= 1'b0;
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("PASS string_key_hash_table");
        end else begin
            $display("FAIL string_key_hash_table");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/skht_pkg.sv
design/skht_ram.sv
design/skht_ctrl.sv
design/skht_dp.sv
design/string_key_hash_table.sv
design/skht_chk.sv
test/tb_string_key_hash_table.sv
